FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CST_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define CST_ASSERT(label, prop, msg)
`define CST_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: rtl/cst_pkg.sv
`default_nettype none
package cst_pkg;

  localparam int SLOTS_PER_GROUP = 16;
  localparam int NUM_GROUPS      = 16;
  localparam int TOTAL_SLOTS     = SLOTS_PER_GROUP * NUM_GROUPS;
  localparam int IDX_W = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
  localparam int GRP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int POS_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS_PER_GROUP + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BAD_ARG  = 3'd1,
    STS_FULL     = 3'd2,
    STS_BAD_SLOT = 3'd3,
    STS_ABSENT   = 3'd4,
    STS_DENIED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CLS_BAD_ARG,
    CLS_BAD_SLOT,
    CLS_INSERT,
    CLS_DELETE,
    CLS_LOOKUP
  } cls_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_INS_GROUP,
    BS_INS_SLOT,
    BS_CHECK
  } bstate_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] object_id;
    logic        object_is_node;
    logic [7:0]  rights;
    logic [8:0]  slot_id;
    logic [15:0] key;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  out_slot_id;
    logic [15:0] out_key;
    logic [31:0] out_object;
  } out_rsp_t;

  typedef struct packed {
    cls_e             cls;
    logic [POS_W-1:0] pos;
    logic [31:0]      object_id;
    logic [7:0]       rights;
    logic [15:0]      key;
  } work_t;

  typedef struct packed {
    logic [31:0] object_id;
    logic [15:0] key;
    logic [3:0]  rights;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/cst_front.sv
`default_nettype none
module cst_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire cst_pkg::in_req_t in_req_i,
  output logic                  work_valid_o,
  output cst_pkg::work_t        work_o,
  input  wire logic             work_pop_i
);
  import cst_pkg::*;

  work_t      fifo_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  work_t      cls_w;
  logic       push;

  // Classify the request so the back end only has to execute it.
  always_comb begin
    cls_w.pos       = POS_W'(in_req_i.slot_id - 9'd1);
    cls_w.object_id = in_req_i.object_id;
    cls_w.rights    = in_req_i.rights;
    cls_w.key       = in_req_i.key;
    case (opcode_e'(in_req_i.opcode))
      OP_INSERT: begin
        if (in_req_i.object_id == 32'd0 || in_req_i.object_is_node ||
            in_req_i.rights[7:4] != 4'd0) begin
          cls_w.cls = CLS_BAD_ARG;
        end else begin
          cls_w.cls = CLS_INSERT;
        end
      end
      OP_DELETE, OP_LOOKUP: begin
        if (in_req_i.slot_id == 9'd0 || {1'b0, in_req_i.slot_id} > 10'(TOTAL_SLOTS)) begin
          cls_w.cls = CLS_BAD_SLOT;
        end else if (opcode_e'(in_req_i.opcode) == OP_DELETE) begin
          cls_w.cls = CLS_DELETE;
        end else begin
          cls_w.cls = CLS_LOOKUP;
        end
      end
      default: cls_w.cls = CLS_BAD_ARG;
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign work_valid_o = (cnt_q != 2'd0);
  assign work_o       = fifo_q[rptr_q];

  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = work_pop_i ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(work_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls_w;
    end
  end

`include "assert_macros.svh"
  `CST_ASSERT(a_pop_nonempty, !work_pop_i || cnt_q != 2'd0, "pop from empty queue")
  `CST_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `CST_ASSERT_NEXT(a_cnt_track, push && !work_pop_i, cnt_q == $past(cnt_q) + 2'd1,
    "queue count lost a push")
endmodule
`default_nettype wire

FILE: rtl/cst_back.sv
`default_nettype none
module cst_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           work_valid_i,
  input  wire cst_pkg::work_t work_i,
  output logic                work_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output cst_pkg::out_rsp_t   out_rsp_o
);
  import cst_pkg::*;

  bstate_e state_q, state_d;
  work_t   cur_q;
  entry_t  mem [TOTAL_SLOTS];
  entry_t  rd_q;
  logic [NUM_GROUPS-1:0][SLOTS_PER_GROUP-1:0] valid_q;
  logic [CNT_W-1:0] count_q [NUM_GROUPS];
  logic [15:0]      seed_q;
  logic [GRP_W-1:0] grp_q;
  logic             out_valid_q, out_valid_d;
  out_rsp_t         rsp_q, rsp_d;

  logic             part_hit, free_hit;
  logic [GRP_W-1:0] part_g, free_g;
  logic [IDX_W-1:0] free_idx;
  logic [POS_W-1:0] ins_pos;
  logic [GRP_W-1:0] cur_g;
  logic [IDX_W-1:0] cur_i;
  logic             cur_hit;
  logic             rsp_load, grp_load, do_insert, do_delete;

  // First present group with room, and first absent group.
  always_comb begin
    part_hit = 1'b0;
    free_hit = 1'b0;
    part_g   = '0;
    free_g   = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (count_q[g] != '0 && count_q[g] != CNT_W'(SLOTS_PER_GROUP)) begin
        part_hit = 1'b1;
        part_g   = GRP_W'(g);
      end
      if (count_q[g] == '0) begin
        free_hit = 1'b1;
        free_g   = GRP_W'(g);
      end
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
      if (!valid_q[grp_q][i]) begin
        free_idx = IDX_W'(i);
      end
    end
    ins_pos = POS_W'(int'(grp_q) * SLOTS_PER_GROUP + int'(free_idx));
  end

  assign cur_g   = GRP_W'(cur_q.pos / SLOTS_PER_GROUP);
  assign cur_i   = IDX_W'(cur_q.pos % SLOTS_PER_GROUP);
  assign cur_hit = valid_q[cur_g][cur_i] && rd_q.key == cur_q.key;

  assign work_pop_o = (state_q == BS_IDLE) && work_valid_i && !out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: begin
        if (work_pop_o) begin
          case (work_i.cls)
            CLS_INSERT:            state_d = BS_INS_GROUP;
            CLS_DELETE, CLS_LOOKUP: state_d = BS_CHECK;
            default:               state_d = BS_IDLE;
          endcase
        end
      end
      BS_INS_GROUP: state_d = (part_hit || free_hit) ? BS_INS_SLOT : BS_IDLE;
      BS_INS_SLOT:  state_d = BS_IDLE;
      BS_CHECK:     state_d = BS_IDLE;
      default:      state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    rsp_d     = '0;
    rsp_load  = 1'b0;
    grp_load  = 1'b0;
    do_insert = 1'b0;
    do_delete = 1'b0;
    case (state_q)
      BS_IDLE: begin
        if (work_pop_o) begin
          if (work_i.cls == CLS_BAD_ARG) begin
            rsp_load     = 1'b1;
            rsp_d.status = STS_BAD_ARG;
          end else if (work_i.cls == CLS_BAD_SLOT) begin
            rsp_load     = 1'b1;
            rsp_d.status = STS_BAD_SLOT;
          end
        end
      end
      BS_INS_GROUP: begin
        grp_load = 1'b1;
        if (!part_hit && !free_hit) begin
          rsp_load     = 1'b1;
          rsp_d.status = STS_FULL;
        end
      end
      BS_INS_SLOT: begin
        do_insert         = 1'b1;
        rsp_load          = 1'b1;
        rsp_d.status      = STS_OK;
        rsp_d.out_slot_id = 9'(ins_pos) + 9'd1;
        rsp_d.out_key     = seed_q;
      end
      BS_CHECK: begin
        rsp_load = 1'b1;
        if (!cur_hit) begin
          rsp_d.status = STS_ABSENT;
        end else if (cur_q.cls == CLS_DELETE) begin
          do_delete    = 1'b1;
          rsp_d.status = STS_OK;
        end else if ((cur_q.rights & ~{4'd0, rd_q.rights}) != 8'd0) begin
          rsp_d.status = STS_DENIED;
        end else begin
          rsp_d.status     = STS_OK;
          rsp_d.out_object = rd_q.object_id;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (rsp_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      out_valid_q <= 1'b0;
      seed_q      <= 16'd0;
      valid_q     <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        count_q[g] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (do_insert) begin
        seed_q                  <= seed_q + 16'd1;
        valid_q[grp_q][free_idx] <= 1'b1;
        count_q[grp_q]          <= count_q[grp_q] + CNT_W'(1);
      end
      if (do_delete) begin
        valid_q[cur_g][cur_i] <= 1'b0;
        count_q[cur_g]        <= count_q[cur_g] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_pop_o) begin
      cur_q <= work_i;
    end
    if (grp_load) begin
      grp_q <= part_hit ? part_g : free_g;
    end
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
    if (do_insert) begin
      mem[ins_pos] <= '{object_id: cur_q.object_id, key: seed_q, rights: cur_q.rights[3:0]};
    end
    rd_q <= mem[work_i.pos];
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`include "assert_macros.svh"
  `CST_ASSERT(a_load_free, !rsp_load || !out_valid_q, "result overwrites pending result")
  `CST_ASSERT(a_ins_room, state_q != BS_INS_SLOT ||
    count_q[grp_q] != CNT_W'(SLOTS_PER_GROUP), "insert into a full group")
  `CST_ASSERT(a_del_count, !do_delete || count_q[cur_g] != '0, "delete from empty group")
  `CST_ASSERT_NEXT(a_check_after_pop, state_q == BS_IDLE && state_d == BS_CHECK,
    out_valid_d, "check state produced no result")
endmodule
`default_nettype wire

FILE: rtl/capability_slot_table_unit.sv
`default_nettype none
// After any queue wait, rejected requests are answered from the idle state; deletes
// and lookups pass the check state, and inserts the group state and, unless the table
// is full, the slot state. The back end executes one request at a time.
// Reset clears slot valid bits, group counts and the key seed at once; no sweep.
// Slot contents memory is not cleared and is read only behind a valid bit.
module capability_slot_table_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire cst_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output cst_pkg::out_rsp_t      out_rsp_o
);
  import cst_pkg::*;

  // The front end checks arguments and slot range as each request arrives
  // and parks the classified request in a two-entry queue, so new requests
  // keep flowing while the back end works, until the queue is full.
  logic  work_valid;
  logic  work_pop;
  work_t work;

  cst_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .work_valid_o (work_valid),
    .work_o       (work),
    .work_pop_i   (work_pop)
  );

  // The back end owns the table: it picks a group and a free slot for
  // inserts, reads the slot memory for deletes and lookups, and holds the
  // finished result in an output register until it is taken.
  cst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_i       (work),
    .work_pop_o   (work_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );
endmodule
`default_nettype wire

FILE: verif/capability_slot_table_unit_tb.sv
`timescale 1ns / 1ps
module capability_slot_table_unit_tb;
  import cst_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  always #2 clk_i = ~clk_i;

  capability_slot_table_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Shadow copy of the table. Entries are only read behind a valid bit.
  logic        shadow_valid [TOTAL_SLOTS];
  logic [31:0] shadow_object[TOTAL_SLOTS];
  logic [15:0] shadow_key   [TOTAL_SLOTS];
  logic [3:0]  shadow_rights[TOTAL_SLOTS];
  int          shadow_count [NUM_GROUPS];
  logic        shadow_present[NUM_GROUPS];
  logic [15:0] shadow_seed;

  // Responses still owed by the table, oldest first.
  out_rsp_t pending_rsp[$];
  int       errors = 0;
  int       n_ins_ok = 0, n_full = 0, n_denied = 0, n_lookup_ok = 0, n_del_ok = 0;
  int       rsp_seen = 0;

  // Hold-off controls shared by the processes below.
  bit          idle_enable = 1'b1;
  bit          long_hold   = 1'b0;
  bit          sender_done = 1'b0;

  // Live handles, so random deletes and lookups hit real entries often.
  logic [8:0]  live_slot[$];
  logic [15:0] live_key[$];

  function automatic out_rsp_t predict_table_op(in_req_t r);
    out_rsp_t rsp;
    int       pos;
    int       g;
    int       i;
    bit       found;
    rsp   = '0;
    found = 1'b0;
    pos   = 0;
    case (opcode_e'(r.opcode))
      OP_INSERT: begin
        if (r.object_id == 0 || r.object_is_node || r.rights[7:4] != 0) begin
          rsp.status = STS_BAD_ARG;
        end else begin
          for (g = 0; g < NUM_GROUPS && !found; g++) begin
            if (shadow_present[g] && shadow_count[g] < SLOTS_PER_GROUP) begin
              for (i = 0; i < SLOTS_PER_GROUP && !found; i++) begin
                if (!shadow_valid[g*SLOTS_PER_GROUP+i]) begin
                  pos   = g*SLOTS_PER_GROUP + i;
                  found = 1'b1;
                end
              end
            end
          end
          if (!found) begin
            for (g = 0; g < NUM_GROUPS && !found; g++) begin
              if (!shadow_present[g]) begin
                shadow_present[g] = 1'b1;
                shadow_count[g]   = 0;
                pos   = g*SLOTS_PER_GROUP;
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            rsp.status = STS_FULL;
          end else begin
            shadow_valid[pos]  = 1'b1;
            shadow_object[pos] = r.object_id;
            shadow_key[pos]    = shadow_seed;
            shadow_rights[pos] = r.rights[3:0];
            shadow_count[pos/SLOTS_PER_GROUP]++;
            rsp.status      = STS_OK;
            rsp.out_slot_id = 9'(pos + 1);
            rsp.out_key     = shadow_seed;
            shadow_seed     = shadow_seed + 16'd1;
          end
        end
      end
      OP_DELETE, OP_LOOKUP: begin
        if (r.slot_id == 0 || r.slot_id > TOTAL_SLOTS) begin
          rsp.status = STS_BAD_SLOT;
        end else begin
          pos = r.slot_id - 1;
          if (!shadow_present[pos/SLOTS_PER_GROUP] || !shadow_valid[pos] ||
              shadow_key[pos] != r.key) begin
            rsp.status = STS_ABSENT;
          end else if (opcode_e'(r.opcode) == OP_DELETE) begin
            rsp.status = STS_OK;
            shadow_valid[pos] = 1'b0;
            g = pos / SLOTS_PER_GROUP;
            if (shadow_count[g] > 0) shadow_count[g]--;
            if (shadow_count[g] == 0) shadow_present[g] = 1'b0;
          end else if ((r.rights & ~{4'h0, shadow_rights[pos]}) != 0) begin
            rsp.status = STS_DENIED;
          end else begin
            rsp.status     = STS_OK;
            rsp.out_object = shadow_object[pos];
          end
        end
      end
      default: rsp.status = STS_BAD_ARG;
    endcase
    return rsp;
  endfunction

  // Predicts one request, checks a typed-in answer where a row has one, and
  // queues the expectation.
  task automatic queue_request(in_req_t r, bit has_fixed, out_rsp_t fixed);
    out_rsp_t rsp;
    rsp = predict_table_op(r);
    if (has_fixed && rsp !== fixed) begin
      $display("%0t: table row disagrees with prediction: expected %h actual %h",
               $time, fixed, rsp);
      errors++;
    end
    if (opcode_e'(r.opcode) == OP_INSERT && rsp.status == STS_OK) begin
      n_ins_ok++;
      live_slot.push_back(rsp.out_slot_id);
      live_key.push_back(rsp.out_key);
    end
    if (rsp.status == STS_FULL) n_full++;
    if (rsp.status == STS_DENIED) n_denied++;
    if (opcode_e'(r.opcode) == OP_LOOKUP && rsp.status == STS_OK) n_lookup_ok++;
    if (opcode_e'(r.opcode) == OP_DELETE && rsp.status == STS_OK) n_del_ok++;
    pending_rsp.push_back(rsp);
  endtask

  // Offers one request and holds it until accepted. Valid stays high when
  // the next request follows back to back.
  task automatic send_request(in_req_t r, bit has_fixed, out_rsp_t fixed);
    int gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    queue_request(r, has_fixed, fixed);
  endtask

  function automatic in_req_t make_req(logic [1:0] op, logic [31:0] obj, logic node,
                                       logic [7:0] rt, logic [8:0] sid, logic [15:0] k);
    in_req_t r;
    r.opcode = op; r.object_id = obj; r.object_is_node = node;
    r.rights = rt; r.slot_id = sid; r.key = k;
    return r;
  endfunction

  function automatic out_rsp_t make_rsp(status_e st, logic [8:0] sid, logic [15:0] k,
                                        logic [31:0] obj);
    out_rsp_t r;
    r.status = st; r.out_slot_id = sid; r.out_key = k; r.out_object = obj;
    return r;
  endfunction

  // Random request: mostly well-formed inserts, deletes and lookups against
  // live handles, with some noise mixed in.
  function automatic in_req_t random_req(int fill_bias);
    in_req_t r;
    int      sel;
    int      idx;
    r   = '0;
    r.object_id = $urandom();
    r.rights    = 8'($urandom_range(0, 15));
    r.slot_id   = 9'($urandom());
    r.key       = 16'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < fill_bias) begin
      r.opcode = OP_INSERT;
      if (r.object_id == 0) r.object_id = 32'h1;
    end else if (sel < 85) begin
      r.opcode = $urandom_range(0, 1) ? OP_DELETE : OP_LOOKUP;
      if (live_slot.size() > 0 && $urandom_range(0, 9) < 8) begin
        idx = $urandom_range(0, live_slot.size() - 1);
        r.slot_id = live_slot[idx];
        r.key     = live_key[idx];
        if ($urandom_range(0, 9) == 0) r.key = r.key ^ 16'(1 << $urandom_range(0, 15));
        if (r.opcode == OP_DELETE) begin
          live_slot.delete(idx);
          live_key.delete(idx);
        end
      end
      if (r.opcode == OP_LOOKUP && $urandom_range(0, 9) == 0) r.rights = 8'($urandom());
    end else begin
      r = in_req_t'({$urandom(), $urandom(), 4'($urandom())});
    end
    return r;
  endfunction

  // Directed table, walked in order after reset. Rows with a typed-in
  // answer check the predictor itself against what is plain from the spec.
  typedef struct {
    in_req_t  req;
    bit       has_fixed;
    out_rsp_t rsp;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    in_req_t r;
    int      n;
    int      i;
    out_rsp_t none;
    none = '0;

    // Null object, table node, high rights bits and the spare opcode.
    directed.push_back('{make_req(OP_INSERT, 32'h0, 1'b0, 8'h0F, 9'd0, 16'd0), 1,
                         make_rsp(STS_BAD_ARG, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_INSERT, 32'hFFFF_FFFF, 1'b1, 8'h0F, 9'd0, 16'd0), 1,
                         make_rsp(STS_BAD_ARG, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_INSERT, 32'h1234, 1'b0, 8'hF0, 9'd0, 16'd0), 1,
                         make_rsp(STS_BAD_ARG, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_RSVD, 32'hFFFF_FFFF, 1'b1, 8'hFF, 9'h1FF, 16'hFFFF), 1,
                         make_rsp(STS_BAD_ARG, 9'd0, 16'd0, 32'd0)});
    // Slot id zero and beyond the table.
    directed.push_back('{make_req(OP_LOOKUP, 32'h0, 1'b0, 8'h00, 9'd0, 16'd0), 1,
                         make_rsp(STS_BAD_SLOT, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_DELETE, 32'h0, 1'b0, 8'h00, 9'h1FF, 16'hFFFF), 1,
                         make_rsp(STS_BAD_SLOT, 9'd0, 16'd0, 32'd0)});
    // Empty table: absent group.
    directed.push_back('{make_req(OP_LOOKUP, 32'h0, 1'b0, 8'h00, 9'd256, 16'd0), 1,
                         make_rsp(STS_ABSENT, 9'd0, 16'd0, 32'd0)});
    // First insert after reset lands in slot 1 with key 0.
    directed.push_back('{make_req(OP_INSERT, 32'hFFFF_FFFF, 1'b0, 8'h0F, 9'd0, 16'd0), 1,
                         make_rsp(STS_OK, 9'd1, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_INSERT, 32'h0000_0001, 1'b0, 8'h01, 9'd0, 16'd0), 1,
                         make_rsp(STS_OK, 9'd2, 16'd1, 32'd0)});
    directed.push_back('{make_req(OP_LOOKUP, 32'h0, 1'b0, 8'h0F, 9'd1, 16'd0), 1,
                         make_rsp(STS_OK, 9'd0, 16'd0, 32'hFFFF_FFFF)});
    // Rights the slot lacks, both low and high bits.
    directed.push_back('{make_req(OP_LOOKUP, 32'h0, 1'b0, 8'h02, 9'd2, 16'd1), 1,
                         make_rsp(STS_DENIED, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_LOOKUP, 32'h0, 1'b0, 8'h80, 9'd1, 16'd0), 1,
                         make_rsp(STS_DENIED, 9'd0, 16'd0, 32'd0)});
    // Key mismatch, present group but empty slot.
    directed.push_back('{make_req(OP_DELETE, 32'h0, 1'b0, 8'h00, 9'd1, 16'hFFFF), 1,
                         make_rsp(STS_ABSENT, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_LOOKUP, 32'h0, 1'b0, 8'h00, 9'd16, 16'd0), 1,
                         make_rsp(STS_ABSENT, 9'd0, 16'd0, 32'd0)});
    // Delete both; the group drops, so the next insert reuses slot 1.
    directed.push_back('{make_req(OP_DELETE, 32'h0, 1'b0, 8'h00, 9'd1, 16'd0), 1,
                         make_rsp(STS_OK, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_DELETE, 32'h0, 1'b0, 8'h00, 9'd2, 16'd1), 1,
                         make_rsp(STS_OK, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_LOOKUP, 32'h0, 1'b0, 8'h00, 9'd2, 16'd1), 1,
                         make_rsp(STS_ABSENT, 9'd0, 16'd0, 32'd0)});
    directed.push_back('{make_req(OP_INSERT, 32'hA5A5_5A5A, 1'b0, 8'h05, 9'd0, 16'd0), 1,
                         make_rsp(STS_OK, 9'd1, 16'd2, 32'd0)});
    directed.push_back('{make_req(OP_LOOKUP, 32'h0, 1'b0, 8'h00, 9'd1, 16'd2), 0, none});

    for (i = 0; i < TOTAL_SLOTS; i++) shadow_valid[i] = 1'b0;
    for (i = 0; i < NUM_GROUPS; i++) begin
      shadow_count[i] = 0;
      shadow_present[i] = 1'b0;
    end
    shadow_seed = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[j]) send_request(directed[j].req, directed[j].has_fixed, directed[j].rsp);

    // Fill the whole table so that inserts report a full table, then drain
    // it with a mix; the receiver holds off for a long stretch meanwhile.
    long_hold = 1'b1;
    for (n = 0; n < 300; n++) begin
      r = random_req(n < 270 ? 95 : 20);
      send_request(r, 0, none);
      if (n == 40) long_hold = 1'b0;
    end

    // Sender pauses until every response has arrived.
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);

    for (n = 0; n < 250; n++) begin
      if (n == 180) idle_enable = 1'b0;
      r = random_req(40);
      send_request(r, 0, none);
    end
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d good inserts, %0d full-table rejects, %0d deletes,",
             n_ins_ok, n_full, n_del_ok);
    $display("%0d good lookups and %0d rights denials over %0d responses.",
             n_lookup_ok, n_denied, rsp_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off counted here.
  initial begin
    int burst;
    int held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold && held == 0) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        held = 1;
        out_stall_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 15);
        out_stall_i <= 1'b1;
        repeat (burst - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Response checker, sampling at the edge where the handshake completes.
  always @(posedge clk_i) begin
    out_rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none expected: actual %h", $time, out_rsp_o);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_rsp_o.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                   out_rsp_o.status);
          errors++;
        end
        if (out_rsp_o.out_slot_id !== exp_rsp.out_slot_id) begin
          $display("%0t: slot id expected %0d actual %0d", $time, exp_rsp.out_slot_id,
                   out_rsp_o.out_slot_id);
          errors++;
        end
        if (out_rsp_o.out_key !== exp_rsp.out_key) begin
          $display("%0t: key expected %h actual %h", $time, exp_rsp.out_key,
                   out_rsp_o.out_key);
          errors++;
        end
        if (out_rsp_o.out_object !== exp_rsp.out_object) begin
          $display("%0t: object expected %h actual %h", $time, exp_rsp.out_object,
                   out_rsp_o.out_object);
          errors++;
        end
      end
    end
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_front.sv
rtl/cst_back.sv
rtl/capability_slot_table_unit.sv
verif/capability_slot_table_unit_tb.sv
